// ----- rtl/core/sha256_pkg.sv -----
// Shared types and constants of the SHA-256 stream hasher.
package sha256_pkg;

   typedef logic [31:0] word_type;

   localparam int unsigned BlockBits = 512;
   localparam int unsigned HashWords = 8;
   localparam int unsigned WindowWords = 16;

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] PadFill = 6'd56;

   localparam word_type InitHash [HashWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic start;
      logic clear;
   } comp_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } comp_stat_type;

endpackage

// ----- rtl/core/sha256_if.sv -----
// Valid/ready channel interfaces for the byte input and the digest output.
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink (input valid, input data_byte, input byte_present,
                 input end_of_message, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

// ----- rtl/core/sha256_comp.sv -----
// SHA-256 compression unit: one round per cycle over a 16-word schedule window.
module sha256_comp (
   input  logic                          clock,
   input  logic                          reset,
   input  sha256_pkg::comp_ctrl_type     ctrl,
   input  logic [sha256_pkg::BlockBits-1:0] block,
   output sha256_pkg::comp_stat_type     stat,
   output sha256_pkg::word_type          hash [sha256_pkg::HashWords]
);

   sha256_pkg::word_type w_ff [sha256_pkg::WindowWords];
   sha256_pkg::word_type w_in [sha256_pkg::WindowWords];
   sha256_pkg::word_type v_ff [sha256_pkg::HashWords];
   sha256_pkg::word_type v_in [sha256_pkg::HashWords];
   sha256_pkg::word_type hash_ff [sha256_pkg::HashWords];
   sha256_pkg::word_type hash_in [sha256_pkg::HashWords];
   logic [5:0] round_ff, round_in;
   logic       busy_ff, busy_in;
   logic       add_ff, add_in;
   logic       done_ff, done_in;

   sha256_pkg::word_type t1, t2, sched_new;

   function automatic sha256_pkg::word_type ror(input sha256_pkg::word_type x,
                                                input int unsigned n);
      ror = (x >> n) | (x << (32 - n));
   endfunction

   always_comb begin
      t1 = v_ff[7] + (ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + sha256_pkg::RoundK[round_ff] + w_ff[0];
      t2 = (ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      sched_new = (ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10)) + w_ff[9]
         + (ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3)) + w_ff[0];
   end

   always_comb begin
      busy_in  = busy_ff;
      add_in   = 1'b0;
      done_in  = 1'b0;
      round_in = round_ff;
      w_in     = w_ff;
      v_in     = v_ff;
      hash_in  = hash_ff;
      if (ctrl.clear) begin
         hash_in = sha256_pkg::InitHash;
      end
      if (ctrl.start) begin
         busy_in  = 1'b1;
         round_in = '0;
         for (int i = 0; i < sha256_pkg::WindowWords; i++) begin
            w_in[i] = block[sha256_pkg::BlockBits - 1 - 32 * i -: 32];
         end
         v_in = hash_ff;
      end else if (add_ff) begin
         for (int i = 0; i < sha256_pkg::HashWords; i++) begin
            hash_in[i] = hash_ff[i] + v_ff[i];
         end
         done_in = 1'b1;
      end else if (busy_ff) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         for (int i = 0; i < sha256_pkg::WindowWords - 1; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[sha256_pkg::WindowWords - 1] = sched_new;
         round_in = round_ff + 6'd1;
         if (round_ff == 6'd63) begin
            busy_in = 1'b0;
            add_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         add_ff   <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
         hash_ff  <= sha256_pkg::InitHash;
      end else begin
         busy_ff  <= busy_in;
         add_ff   <= add_in;
         done_ff  <= done_in;
         round_ff <= round_in;
         hash_ff  <= hash_in;
      end
      w_ff <= w_in;
      v_ff <= v_in;
   end

   assign stat.busy = busy_ff | add_ff;
   assign stat.done = done_ff;
   assign hash      = hash_ff;

endmodule

// ----- rtl/core/sha256_stream_hasher.sv -----
// Top level of the SHA-256 stream hasher: byte packing, padding and digest output.
//
//   Channel  Direction  Item contents
//   req      in         data_byte, byte_present, end_of_message
//   rsp      out        digest_word, word_index, last_word (eight items per message)
//
// A byte item is taken whenever ready is high. The item that fills a 64-byte block holds ready
// low while the compression unit runs its 64 rounds, one per cycle, and updates the hash.
// At message end, padding bytes and the eight length bytes go in one per cycle while no
// block is compressing; one or two blocks are compressed, then the eight digest items are
// offered in order. Reset is synchronous; rsp stalls simply hold the current digest item.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_COMP = 5'b00010,
      S_PAD  = 5'b00100,
      S_LEN  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [sha256_pkg::BlockBits-1:0] blk_ff, blk_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        pend_ff, pend_in;
   logic        fin_ff, fin_in;
   logic        sent_ff, sent_in;
   logic [2:0]  lcnt_ff, lcnt_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic        push;
   logic [7:0]  push_byte;

   sha256_pkg::comp_ctrl_type ctrl;
   sha256_pkg::comp_stat_type stat;
   sha256_pkg::word_type      hash [sha256_pkg::HashWords];

   sha256_comp u_comp (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .block (blk_in),
      .stat  (stat),
      .hash  (hash)
   );

   always_comb begin
      state_in   = state_ff;
      blk_in     = blk_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      pend_in    = pend_ff;
      fin_in     = fin_ff;
      sent_in    = sent_ff;
      lcnt_in    = lcnt_ff;
      oidx_in    = oidx_ff;
      push       = 1'b0;
      push_byte  = '0;
      ctrl.start = 1'b0;
      ctrl.clear = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               if (req.byte_present) begin
                  push      = 1'b1;
                  push_byte = req.data_byte;
                  bits_in   = bits_ff + 64'd8;
               end
               if (req.byte_present && fill_ff == 6'd63) begin
                  ctrl.start = 1'b1;
                  pend_in    = req.end_of_message;
                  fin_in     = 1'b0;
                  sent_in    = 1'b0;
                  state_in   = S_COMP;
               end else if (req.end_of_message) begin
                  sent_in  = 1'b0;
                  state_in = S_PAD;
               end
            end
         end
         S_COMP: begin
            if (stat.done) begin
               if (fin_ff) begin
                  state_in = S_OUT;
               end else if (pend_ff) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PAD: begin
            if (!sent_ff) begin
               push      = 1'b1;
               push_byte = sha256_pkg::PadByte;
               sent_in   = 1'b1;
            end else if (fill_ff == sha256_pkg::PadFill) begin
               lcnt_in  = '0;
               state_in = S_LEN;
            end else begin
               push      = 1'b1;
               push_byte = '0;
            end
            if (push && fill_ff == 6'd63) begin
               ctrl.start = 1'b1;
               pend_in    = 1'b1;
               fin_in     = 1'b0;
               state_in   = S_COMP;
            end
         end
         S_LEN: begin
            push      = 1'b1;
            push_byte = bits_ff[63:56];
            bits_in   = {bits_ff[55:0], 8'h00};
            lcnt_in   = lcnt_ff + 3'd1;
            if (lcnt_ff == 3'd7) begin
               ctrl.start = 1'b1;
               fin_in     = 1'b1;
               state_in   = S_COMP;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  ctrl.clear = 1'b1;
                  fill_in    = '0;
                  bits_in    = '0;
                  pend_in    = 1'b0;
                  fin_in     = 1'b0;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (push) begin
         blk_in  = {blk_ff[sha256_pkg::BlockBits-9:0], push_byte};
         fill_in = fill_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         pend_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         sent_ff  <= 1'b0;
         lcnt_ff  <= '0;
         oidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         pend_ff  <= pend_in;
         fin_ff   <= fin_in;
         sent_ff  <= sent_in;
         lcnt_ff  <= lcnt_in;
         oidx_ff  <= oidx_in;
      end
      blk_ff <= blk_in;
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = (state_ff == S_OUT);
   assign rsp.digest_word = hash[oidx_ff];
   assign rsp.word_index  = oidx_ff;
   assign rsp.last_word   = (oidx_ff == 3'd7);

   // The digest is only offered once the final compression has fully settled.
   a_out_idle_unit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !stat.busy)
      else $error("digest offered while compression unit is busy");

   a_start_idle_unit: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !stat.busy)
      else $error("compression started while unit is busy");

   a_done_in_comp: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> state_ff == S_COMP)
      else $error("compression finished outside the wait state");

   a_clean_restart: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last_word |=> fill_ff == '0 && bits_ff == '0 && req.ready)
      else $error("message state not cleared after last digest item");

endmodule
